@@ src/dewpt_pkg.sv @@
// Shared constants, types and table functions for the dew point unit.
`default_nettype none
package dewpt_pkg;

  localparam int LOG_TABLE_DEPTH_DEF = 64;

  // unsigned quotient by shift and subtract, used for table constants only
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], n[i]};
      if (r >= d) begin
        r    = r - d;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Q30 series for ln((1+z)/(1-z)) = 2*atanh(z), z given in Q30
  function automatic longint unsigned ln_series(input longint unsigned z);
    longint unsigned z2;
    longint unsigned term;
    longint unsigned sum;
    z2   = (z * z) >> 30;
    term = z;
    sum  = 64'd0;
    for (int n = 0; n < 24; n++) begin
      sum  = sum + udiv64(term, 64'(2 * n + 1));
      term = (term * z2) >> 30;
    end
    return 64'd2 * sum;
  endfunction

  localparam longint unsigned LN2_Z   = (64'd1 << 30) / 64'd3;
  localparam longint unsigned LN10K_Z = (64'd1808 << 30) / 64'd18192;
  localparam longint unsigned LN_TWO  = ln_series(LN2_Z);
  localparam longint unsigned LN_10K  = 64'd13 * LN_TWO + ln_series(LN10K_Z);

  localparam int LNW = 35;  // ln(RH/100) in signed Q30

  localparam logic signed [20:0] TN_OFS  = 21'sd218808;
  localparam logic signed [46:0] B_Q30   = 47'sd1762 <<< 30;
  localparam logic signed [39:0] HQ_MIN  = -(40'sd100 <<< 30);
  localparam logic [24:0]        K_MET   = 25'd2431200;
  localparam logic [24:0]        K_IMP   = 25'd21880800;
  localparam logic signed [18:0] F_OFS   = 19'sd3200;
  localparam logic signed [18:0] DP_LOW  = -19'sd16000;
  localparam logic signed [18:0] DP_HIGH = 19'sd18500;

  typedef struct packed {
    logic        hz;
    logic [15:0] temp;
  } ln_side_t;

  typedef struct packed {
    logic                  hz;
    logic                  cneg;
    logic                  neg;
    logic signed [LNW-1:0] lnh;
  } d1_side_t;

  typedef struct packed {
    logic hz;
    logic cneg;
    logic bneg;
    logic neg;
  } d2_side_t;

endpackage
`default_nettype wire

@@ src/dewpt_ln.sv @@
// Pipelined ln(RH/100): leading-one normalize, table lookup, linear interpolation.
`default_nettype none
module dewpt_ln #(
  parameter int DEPTH = dewpt_pkg::LOG_TABLE_DEPTH_DEF,
  parameter int SW    = 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              en_i,
  input  wire logic                              valid_i,
  input  wire logic [13:0]                       hum_i,
  input  wire logic [SW-1:0]                     side_i,
  output logic                                   valid_o,
  output logic signed [dewpt_pkg::LNW-1:0]       ln_o,
  output logic [SW-1:0]                          side_o
);

  localparam int IW = $clog2(DEPTH);
  localparam int TW = $clog2(DEPTH + 1);
  localparam int PW = 14 + TW;

  logic [29:0] ln_tab [DEPTH+1];

  for (genvar k = 0; k <= DEPTH; k++) begin : g_tab
    localparam longint unsigned Z = dewpt_pkg::udiv64(64'(k) << 30, 64'(2 * DEPTH + k));
    assign ln_tab[k] = 30'(dewpt_pkg::ln_series(Z));
  end

  logic [4:0] vld_q;
  logic [SW-1:0] side1_q, side2_q, side3_q, side4_q, side5_q;

  // stage 1: exponent and mantissa
  logic [3:0]  exp_d;
  logic [14:0] norm_d;
  logic [3:0]  exp1_q, exp2_q;
  logic [13:0] man1_q;

  always_comb begin
    exp_d = 4'd0;
    for (int b = 1; b < 14; b++) begin
      if (hum_i[b]) exp_d = 4'(b);
    end
    norm_d = 15'(hum_i) << (5'd14 - 5'(exp_d));
  end

  // stage 2: segment position
  logic [PW-1:0] pos_q;

  // stage 3: table reads
  logic [TW-1:0] idx0, idx1;
  logic [29:0]   t0_q, t1_q;
  logic [13:0]   frac3_q;
  logic [33:0]   eln_q;

  assign idx0 = TW'(pos_q[14 +: IW]);
  assign idx1 = idx0 + TW'(1);

  // stage 4: base and interpolation product
  logic signed [35:0] base_q;
  logic [43:0]        prod_q;
  logic [29:0]        diff;

  assign diff = t1_q - t0_q;

  // stage 5
  logic signed [35:0] ln_d;
  assign ln_d = base_q + $signed({6'd0, prod_q[43:14]});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      exp1_q  <= exp_d;
      man1_q  <= norm_d[13:0];
      side1_q <= side_i;

      pos_q   <= PW'(man1_q) * PW'(DEPTH);
      exp2_q  <= exp1_q;
      side2_q <= side1_q;

      t0_q    <= ln_tab[idx0];
      t1_q    <= ln_tab[idx1];
      frac3_q <= pos_q[13:0];
      eln_q   <= 34'(exp2_q) * 34'(dewpt_pkg::LN_TWO);
      side3_q <= side2_q;

      base_q  <= $signed({2'b0, eln_q}) + $signed({6'b0, t0_q})
                 - $signed(36'(dewpt_pkg::LN_10K));
      prod_q  <= 44'(diff) * 44'(frac3_q);
      side4_q <= side3_q;

      ln_o    <= ln_d[dewpt_pkg::LNW-1:0];
      side5_q <= side4_q;
    end
  end

  assign valid_o = vld_q[4];
  assign side_o  = side5_q;

endmodule
`default_nettype wire

@@ src/dewpt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, rounded; the top quotient bit flags overflow.
`default_nettype none
module dewpt_div #(
  parameter int NW = 59,
  parameter int DW = 26,
  parameter int QW = 38,
  parameter int SW = 1
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [NW-1:0] num_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [SW-1:0] side_i,
  output logic               valid_o,
  output logic [QW:0]        quo_o,   // top bit set: quotient does not fit in QW bits
  output logic [SW-1:0]      side_o
);

  localparam int CW = (NW + 1 > DW + QW + 1) ? NW + 1 : DW + QW + 1;

  logic [CW-1:0] rem_q  [QW+1];
  logic [DW-1:0] den_q  [QW+1];
  logic [QW:0]   quo_q  [QW+2];
  logic [SW-1:0] side_q [QW+2];
  logic [QW+1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[QW:0], valid_i};
    end
  end

  // prep: add half the divisor for round-half-away
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= CW'(num_i) + CW'(den_i >> 1);
      den_q[0]  <= den_i;
      quo_q[0]  <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 0; j <= QW; j++) begin : g_stage
    localparam int SH = QW - j;
    logic [CW-1:0] dsh;
    logic          ge;
    assign dsh = CW'(den_q[j]) << SH;
    assign ge  = rem_q[j] >= dsh;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        quo_q[j+1]  <= {quo_q[j][QW-1:0], ge};
        side_q[j+1] <= side_q[j];
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[j+1] <= ge ? rem_q[j] - dsh : rem_q[j];
          den_q[j+1] <= den_q[j];
        end
      end
    end
  end

  assign valid_o = vld_q[QW+1];
  assign quo_o   = quo_q[QW+1];
  assign side_o  = side_q[QW+1];

endmodule
`default_nettype wire

@@ src/dew_point_from_temp_humidity_unit.sv @@
// Top level of the Magnus dew point unit: stream ports, config register, pipeline.
// Pipeline order from input transfer to result valid: ln, prep, first divider,
//   H sum, products, second divider, output.
// Throughput: one transfer per cycle; a stalled output holds the whole pipeline.
// Reset: asynchronous active low; clears valid bits and sets Celsius mode.
`default_nettype none
module dew_point_from_temp_humidity_unit #(
  parameter int LOG_TABLE_DEPTH = dewpt_pkg::LOG_TABLE_DEPTH_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [15:0] temperature, [29:16] humidity
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // [15:0] dew_point
  output logic             m_axis_tuser,   // [0] no_humidity
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_data_i
);

  logic adv;
  logic imp_q;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imp_q <= 1'b0;
    end else if (cfg_valid_i) begin
      imp_q <= cfg_data_i;
    end
  end

  // ln stage
  dewpt_pkg::ln_side_t ln_in, ln_out;
  logic ln_vld;
  logic signed [dewpt_pkg::LNW-1:0] lnh;

  assign ln_in.hz   = (s_axis_tdata[29:16] == 14'd0);
  assign ln_in.temp = s_axis_tdata[15:0];

  dewpt_ln #(
    .DEPTH (LOG_TABLE_DEPTH),
    .SW    ($bits(dewpt_pkg::ln_side_t))
  ) u_ln (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s_axis_tvalid && s_axis_tready),
    .hum_i   (s_axis_tdata[29:16]),
    .side_i  (ln_in),
    .valid_o (ln_vld),
    .ln_o    (lnh),
    .side_o  (ln_out)
  );

  // prep: temperature in 1/900 C, b*T/(c+T) operands
  logic signed [19:0] t_s, tn;
  logic signed [30:0] bt;
  logic [28:0]        bt_mag;
  logic signed [20:0] c_sum;
  logic signed [27:0] c_den;
  logic               cneg;

  assign t_s    = 20'($signed(ln_out.temp));
  assign tn     = imp_q ? (t_s - 20'sd3200) * 20'sd5 : t_s * 20'sd9;
  assign bt     = 31'(tn) * 31'sd1762;
  assign bt_mag = 29'(bt < 0 ? -bt : bt);
  assign c_sum  = 21'(tn) + dewpt_pkg::TN_OFS;
  assign cneg   = c_sum <= 0;
  assign c_den  = 28'(c_sum) * 28'sd100;

  logic                p_vld_q;
  logic [58:0]         p_num_q;
  logic [25:0]         p_den_q;
  dewpt_pkg::d1_side_t p_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q <= 1'b0;
    end else if (adv) begin
      p_vld_q <= ln_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_num_q       <= {bt_mag, 30'd0};
      p_den_q       <= cneg ? 26'd1 : 26'(c_den);
      p_side_q.hz   <= ln_out.hz;
      p_side_q.cneg <= cneg;
      p_side_q.neg  <= tn < 0;
      p_side_q.lnh  <= lnh;
    end
  end

  logic                d1_vld;
  logic [38:0]         d1_quo;
  dewpt_pkg::d1_side_t d1_side;

  dewpt_div #(
    .NW (59),
    .DW (26),
    .QW (38),
    .SW ($bits(dewpt_pkg::d1_side_t))
  ) u_div_h (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (p_vld_q),
    .num_i   (p_num_q),
    .den_i   (p_den_q),
    .side_i  (p_side_q),
    .valid_o (d1_vld),
    .quo_o   (d1_quo),
    .side_o  (d1_side)
  );

  // H = ln term + b*T/(c+T), clamped below
  logic [37:0]        q1;
  logic signed [39:0] q1_s, h_sum;
  logic signed [37:0] h_d;

  assign q1    = d1_quo[38] ? '1 : d1_quo[37:0];
  assign q1_s  = $signed({2'b0, q1});
  assign h_sum = 40'(d1_side.lnh) + (d1_side.neg ? -q1_s : q1_s);
  assign h_d   = (h_sum < dewpt_pkg::HQ_MIN) ? 38'(dewpt_pkg::HQ_MIN) : h_sum[37:0];

  logic               h_vld_q, h_hz_q, h_cneg_q;
  logic signed [37:0] h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_vld_q <= 1'b0;
    end else if (adv) begin
      h_vld_q <= d1_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_q      <= h_d;
      h_hz_q   <= d1_side.hz;
      h_cneg_q <= d1_side.cneg;
    end
  end

  // partial products of c*H and the b-H denominator
  logic [36:0]        h_mag;
  logic [24:0]        kmul;
  logic signed [46:0] bden;
  logic               bneg;
  logic signed [46:0] bden_sc;

  assign h_mag   = 37'(h_q < 0 ? -h_q : h_q);
  assign kmul    = imp_q ? dewpt_pkg::K_IMP : dewpt_pkg::K_MET;
  assign bden    = dewpt_pkg::B_Q30 - 47'(h_q) * 47'sd100;
  assign bneg    = bden <= 0;
  assign bden_sc = imp_q ? bden * 47'sd5 : bden;

  logic                m1_vld_q;
  logic [44:0]         plo_q;
  logic [41:0]         phi_q;
  logic [45:0]         m1_den_q;
  dewpt_pkg::d2_side_t m1_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
    end else if (adv) begin
      m1_vld_q <= h_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      plo_q          <= 45'(h_mag[19:0]) * 45'(kmul);
      phi_q          <= 42'(h_mag[36:20]) * 42'(kmul);
      m1_den_q       <= bneg ? 46'd1 : 46'(bden_sc);
      m1_side_q.hz   <= h_hz_q;
      m1_side_q.cneg <= h_cneg_q;
      m1_side_q.bneg <= bneg;
      m1_side_q.neg  <= h_q < 0;
    end
  end

  logic                m2_vld_q;
  logic [61:0]         m2_num_q;
  logic [45:0]         m2_den_q;
  dewpt_pkg::d2_side_t m2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m2_vld_q <= 1'b0;
    end else if (adv) begin
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m2_num_q  <= {phi_q, 20'd0} + 62'(plo_q);
      m2_den_q  <= m1_den_q;
      m2_side_q <= m1_side_q;
    end
  end

  logic                d2_vld;
  logic [16:0]         d2_quo;
  dewpt_pkg::d2_side_t d2_side;

  dewpt_div #(
    .NW (62),
    .DW (46),
    .QW (16),
    .SW ($bits(dewpt_pkg::d2_side_t))
  ) u_div_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (m2_vld_q),
    .num_i   (m2_num_q),
    .den_i   (m2_den_q),
    .side_i  (m2_side_q),
    .valid_o (d2_vld),
    .quo_o   (d2_quo),
    .side_o  (d2_side)
  );

  // sign, unit offset, special cases, saturation
  logic [15:0]        q2;
  logic signed [18:0] dv0, dv1, dv;

  always_comb begin
    q2  = d2_quo[16] ? 16'hFFFF : d2_quo[15:0];
    dv0 = $signed({3'b0, q2});
    dv1 = (d2_side.neg ? -dv0 : dv0) + (imp_q ? dewpt_pkg::F_OFS : 19'sd0);
    if (d2_side.hz) begin
      dv = 19'sd0;
    end else if (d2_side.cneg) begin
      dv = dewpt_pkg::DP_LOW;
    end else if (d2_side.bneg) begin
      dv = dewpt_pkg::DP_HIGH;
    end else if (dv1 < dewpt_pkg::DP_LOW) begin
      dv = dewpt_pkg::DP_LOW;
    end else if (dv1 > dewpt_pkg::DP_HIGH) begin
      dv = dewpt_pkg::DP_HIGH;
    end else begin
      dv = dv1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= d2_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_axis_tdata <= dv[15:0];
      m_axis_tuser <= d2_side.hz;
    end
  end

endmodule
`default_nettype wire

@@ src/dewpt_checker.sv @@
// Port-level checker for the dew point unit, bound to the top level.
`default_nettype none
module dewpt_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [15:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        cfg_ready_o
);

  a_nohum_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("no_humidity result with nonzero dew point");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata) >= -16'sd16000)
                   && ($signed(m_axis_tdata) <= 16'sd18500))
    else $error("dew point out of range");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled result changed");

  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output stall");

  a_cfg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config write refused");

endmodule

bind dew_point_from_temp_humidity_unit dewpt_checker u_dewpt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .cfg_ready_o   (cfg_ready_o)
);
`default_nettype wire
